// File: src/mfr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and controller/datapath interface types.
package mfr_pkg;

	localparam int DEF_SCREEN_WIDTH  = 256;
	localparam int DEF_SCREEN_HEIGHT = 128;

	localparam int COORD_W  = 12;
	localparam int COLOUR_W = 8;
	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;

	localparam logic [BYTE_W-1:0] BYTE_ALL = 8'hff;

	localparam logic [OP_W-1:0] OP_SET  = 2'd0;
	localparam logic [OP_W-1:0] OP_GET  = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL = 2'd2;
	localparam logic [OP_W-1:0] OP_INV  = 2'd3;

	typedef struct packed {
		logic load;
		logic init;
		logic row;
		logic span;
		logic clear_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic empty;
		logic span_last;
		logic rows_done;
	} status_t;

endpackage

// File: src/mfr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/mfr_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: clearing pass, row and byte-span walk, result handoff.
module mfr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  mfr_pkg::status_t status,
	output mfr_pkg::cmd_t   cmd
);

	import mfr_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_INIT   = 3'd2;
	localparam logic [2:0] S_ROW    = 3'd3;
	localparam logic [2:0] S_SPAN   = 3'd4;
	localparam logic [2:0] S_DRAIN  = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = status.empty ? S_FINISH : S_ROW;
			end
			S_ROW: begin
				cmd.row = 1'b1;
				state_d = S_SPAN;
			end
			S_SPAN: begin
				cmd.span = 1'b1;
				if (status.span_last) begin
					state_d = status.rows_done ? S_DRAIN : S_ROW;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: src/mfr_dpath.sv
`timescale 1ns / 1ps
// Datapath: clamping, row addressing, byte masks, read-modify-write and result register.
module mfr_dpath #(
	parameter int SCREEN_WIDTH  = mfr_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = mfr_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mfr_pkg::cmd_t                  cmd,
	output mfr_pkg::status_t               status,
	input  logic [mfr_pkg::OP_W-1:0]       operation,
	input  logic [mfr_pkg::COORD_W-1:0]    left,
	input  logic [mfr_pkg::COORD_W-1:0]    top,
	input  logic [mfr_pkg::COORD_W-1:0]    right,
	input  logic [mfr_pkg::COORD_W-1:0]    bottom,
	input  logic [mfr_pkg::COLOUR_W-1:0]   colour,
	output logic [mfr_pkg::BYTE_W-1:0]     pixel_value,
	output logic                           done_res
);

	import mfr_pkg::*;

	localparam int XW     = $clog2(SCREEN_WIDTH);
	localparam int YW     = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int NPIX   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int NPW    = ($clog2(NPIX) + 1 > 4) ? $clog2(NPIX) + 1 : 4;
	localparam int BW     = NPW - 3;
	localparam int DEPTH  = (NPIX + 7) / 8;
	localparam int RAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [COORD_W-1:0] X_LAST_C = COORD_W'(SCREEN_WIDTH - 1);
	localparam logic [COORD_W-1:0] Y_LAST_C = COORD_W'(SCREEN_HEIGHT - 1);
	localparam logic [XW-1:0]      X_LAST   = XW'(SCREEN_WIDTH - 1);
	localparam logic [YW-1:0]      Y_LAST   = YW'(SCREEN_HEIGHT - 1);

	// clamped coordinates
	logic [XW-1:0] x0c, x1c;
	logic [YW-1:0] y0c, y1c;

	logic [OP_W-1:0] op_q;
	logic            lit_q;
	logic [XW-1:0]   x0_q;
	logic [XW:0]     x1_q;
	logic [YW-1:0]   y0_q;
	logic [YW:0]     y1_q;
	logic [YW:0]     row_q;
	logic [YW:0]     row_inc;
	logic [NPW-1:0]  base_q;
	logic [NPW-1:0]  na, nb;
	logic [BW-1:0]   fb_q, lb_q, cur_q;
	logic [2:0]      sb_q, eb_q;
	logic [BYTE_W-1:0] mask_c;

	logic              valid_s1;
	logic [BW-1:0]     addr_s1;
	logic [BYTE_W-1:0] mask_s1;

	logic              wr_valid_q;
	logic [BW-1:0]     wr_addr_q;
	logic [BYTE_W-1:0] wr_data_q;

	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] rd_byte;
	logic [BYTE_W-1:0] new_byte;
	logic              mod_we;

	logic [RAW-1:0]    clr_q;
	logic              ram_we;
	logic [RAW-1:0]    ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;

	logic              pix_bit_q;
	logic [BYTE_W-1:0] pixel_q;
	logic              done_q;

	assign x0c = (left   >= X_LAST_C) ? X_LAST : left[XW-1:0];
	assign x1c = (right  >= X_LAST_C) ? X_LAST : right[XW-1:0];
	assign y0c = (top    >= Y_LAST_C) ? Y_LAST : top[YW-1:0];
	assign y1c = (bottom >= Y_LAST_C) ? Y_LAST : bottom[YW-1:0];

	assign na      = base_q + NPW'(x0_q);
	assign nb      = base_q + NPW'(x1_q) - NPW'(1);
	assign row_inc = row_q + (YW+1)'(1);

	assign mask_c = ((cur_q == fb_q) ? (BYTE_ALL << sb_q) : BYTE_ALL)
		& ((cur_q == lb_q) ? (BYTE_ALL >> (3'd7 - eb_q)) : BYTE_ALL);

	assign status.empty      = ({1'b0, x0_q} >= x1_q) || ({1'b0, y0_q} >= y1_q);
	assign status.span_last  = (cur_q == lb_q);
	assign status.rows_done  = (row_inc == y1_q);
	assign status.clear_last = (clr_q == RAW'(DEPTH - 1));

	// operand capture and row/byte walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			lit_q <= (colour != '0);
			x0_q  <= x0c;
			y0_q  <= y0c;
			if (operation == OP_SET || operation == OP_GET) begin
				x1_q <= {1'b0, x0c} + (XW+1)'(1);
				y1_q <= {1'b0, y0c} + (YW+1)'(1);
			end else begin
				x1_q <= {1'b0, x1c};
				y1_q <= {1'b0, y1c};
			end
		end
		if (cmd.init) begin
			base_q <= NPW'(y0_q) * NPW'(SCREEN_WIDTH);
			row_q  <= {1'b0, y0_q};
		end
		if (cmd.row) begin
			fb_q  <= na[NPW-1:3];
			lb_q  <= nb[NPW-1:3];
			sb_q  <= na[2:0];
			eb_q  <= nb[2:0];
			cur_q <= na[NPW-1:3];
		end
		if (cmd.span) begin
			cur_q <= cur_q + BW'(1);
			if (status.span_last) begin
				base_q <= base_q + NPW'(SCREEN_WIDTH);
				row_q  <= row_inc;
			end
		end
		addr_s1 <= cur_q;
		mask_s1 <= mask_c;
		wr_addr_q <= addr_s1;
		wr_data_q <= new_byte;
		if (valid_s1) begin
			pix_bit_q <= |(rd_byte & mask_s1);
		end
		if (cmd.out_load) begin
			pixel_q <= (op_q == OP_GET && pix_bit_q) ? BYTE_ALL : '0;
			done_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			wr_valid_q <= 1'b0;
			clr_q      <= '0;
		end else begin
			valid_s1   <= cmd.span;
			wr_valid_q <= mod_we;
			if (cmd.clear_step) begin
				clr_q <= clr_q + RAW'(1);
			end
		end
	end

	// take the byte written last cycle if the read raced it
	assign rd_byte = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : ram_rdata;

	always_comb begin
		case (op_q)
			OP_INV:  new_byte = rd_byte ^ mask_s1;
			OP_GET:  new_byte = rd_byte;
			default: new_byte = lit_q ? (rd_byte | mask_s1) : (rd_byte & ~mask_s1);
		endcase
	end

	assign mod_we    = valid_s1 && (op_q != OP_GET);
	assign ram_we    = cmd.clear_step || mod_we;
	assign ram_waddr = cmd.clear_step ? clr_q : addr_s1[RAW-1:0];
	assign ram_wdata = cmd.clear_step ? BYTE_ALL : new_byte;

	mfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cur_q[RAW-1:0]),
		.rdata(ram_rdata)
	);

	assign pixel_value = pixel_q;
	assign done_res    = done_q;

endmodule

// File: src/mono_framebuffer_rect_engine.sv
`timescale 1ns / 1ps
// Top level of the one-bit-per-pixel framebuffer point and rectangle engine.
//
// Input channel (in_valid / in_stall) carries one operation per item: set point,
// get point, fill rectangle, invert rectangle. Coordinates are clamped to the
// last column/row; rectangles cover [left,right) x [top,bottom).
// Output channel (out_valid / out_stall) returns one item per operation:
// pixel_value (255 or 0 for get point, 0 otherwise) and done_res = 1.
// Work is one framebuffer byte per cycle, with a setup step before each row,
// as a read-modify-write over the RAM's registered read port and its write
// port, with write-to-read bypass. A rectangle walks its rows in order and
// each row's touched bytes in order; an empty one goes straight to the result.
// One item is in work at a time; the next item is taken once the previous
// result sits in the output register.
// After reset the store is swept to all white, one byte per cycle
// ((SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8 bytes, 4096 by default) with
// in_stall high. A stalled output holds its result; the next item is still
// taken and worked, and its final step waits with in_stall high until the
// held result is taken.
module mono_framebuffer_rect_engine #(
	parameter int SCREEN_WIDTH  = mfr_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = mfr_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mfr_pkg::OP_W-1:0]     operation,
	input  logic [mfr_pkg::COORD_W-1:0]  left,
	input  logic [mfr_pkg::COORD_W-1:0]  top,
	input  logic [mfr_pkg::COORD_W-1:0]  right,
	input  logic [mfr_pkg::COORD_W-1:0]  bottom,
	input  logic [mfr_pkg::COLOUR_W-1:0] colour,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mfr_pkg::BYTE_W-1:0]   pixel_value,
	output logic                         done_res
);

	import mfr_pkg::*;

	cmd_t    cmd;
	status_t status;

	mfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	mfr_dpath #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.operation  (operation),
		.left       (left),
		.top        (top),
		.right      (right),
		.bottom     (bottom),
		.colour     (colour),
		.pixel_value(pixel_value),
		.done_res   (done_res)
	);

endmodule

// File: tb/mono_framebuffer_rect_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the 1bpp framebuffer point and rectangle engine.
module mono_framebuffer_rect_engine_tb;
	import mfr_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int SCR_W       = DEF_SCREEN_WIDTH;
	localparam int SCR_H       = DEF_SCREEN_HEIGHT;
	localparam int FRAME_BYTES = (SCR_W * SCR_H + 7) / 8;
	localparam int N_RANDOM    = 120;
	localparam int CALM_TAIL   = 25;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 64;
	// Worst legal run: ~150 full-screen items, plus the clearing sweep and
	// stalls; allow about four times that.
	localparam int CYCLE_LIMIT = 3_000_000;

	class frame_predictor;
		typedef struct packed {
			logic [BYTE_W-1:0] pixel;
			logic              done;
		} reply_t;

		logic [BYTE_W-1:0] frame [FRAME_BYTES];
		reply_t            pending_replies [$];
		int                mismatches;
		int                checked;
		int                lit_reads;
		int                dark_reads;
		int                op_count [4];

		function new();
			foreach (frame[i])
				frame[i] = BYTE_ALL;
			mismatches = 0;
			checked    = 0;
			lit_reads  = 0;
			dark_reads = 0;
			foreach (op_count[i])
				op_count[i] = 0;
		endfunction

		function int unsigned clamp(logic [COORD_W-1:0] v, int unsigned lim);
			return (v >= lim) ? lim - 1 : int'(v);
		endfunction

		function void touch(int unsigned x, int unsigned y, bit lit, bit flip);
			int unsigned n;
			int unsigned idx;
			logic [BYTE_W-1:0] mask;
			n    = x + SCR_W * y;
			idx  = n >> 3;
			mask = 8'd1 << (n & 7);
			if (flip)
				frame[idx] = frame[idx] ^ mask;
			else if (lit)
				frame[idx] = frame[idx] | mask;
			else
				frame[idx] = frame[idx] & ~mask;
		endfunction

		function void note_operation(logic [OP_W-1:0] op, logic [COORD_W-1:0] l,
				logic [COORD_W-1:0] t, logic [COORD_W-1:0] r, logic [COORD_W-1:0] b,
				logic [COLOUR_W-1:0] c);
			int unsigned x0, y0, x1, y1;
			int unsigned n;
			bit lit;
			reply_t reply;
			x0 = clamp(l, SCR_W);
			y0 = clamp(t, SCR_H);
			x1 = clamp(r, SCR_W);
			y1 = clamp(b, SCR_H);
			lit = (c != 0);
			reply.pixel = '0;
			reply.done  = 1'b1;
			op_count[op]++;
			case (op)
				OP_SET: touch(x0, y0, lit, 1'b0);
				OP_GET: begin
					n = x0 + SCR_W * y0;
					if (frame[n >> 3][n & 7]) begin
						reply.pixel = BYTE_ALL;
						lit_reads++;
					end else begin
						dark_reads++;
					end
				end
				default: begin
					for (int unsigned y = y0; y < y1; y++)
						for (int unsigned x = x0; x < x1; x++)
							touch(x, y, lit, op == OP_INV);
				end
			endcase
			pending_replies.push_back(reply);
		endfunction

		function void check_reply(logic [BYTE_W-1:0] pixel, logic done);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$error("result with nothing expected: pixel_value %0d done_res %0d",
					pixel, done);
				mismatches++;
				return;
			end
			want = pending_replies.pop_front();
			checked++;
			if (pixel !== want.pixel) begin
				$error("pixel_value: expected %0d, actual %0d", want.pixel, pixel);
				mismatches++;
			end
			if (done !== want.done) begin
				$error("done_res: expected %0d, actual %0d", want.done, done);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     operation;
	logic [COORD_W-1:0]  left;
	logic [COORD_W-1:0]  top;
	logic [COORD_W-1:0]  right;
	logic [COORD_W-1:0]  bottom;
	logic [COLOUR_W-1:0] colour;
	logic                out_valid;
	logic                out_stall;
	logic [BYTE_W-1:0]   pixel_value;
	logic                done_res;

	frame_predictor predictor;
	bit             calm;
	int             hot_x;
	int             hot_y;
	int             cycles;

	mono_framebuffer_rect_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.left        (left),
		.top         (top),
		.right       (right),
		.bottom      (bottom),
		.colour      (colour),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_value (pixel_value),
		.done_res    (done_res)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			predictor.check_reply(pixel_value, done_res);
	end

	// Result side: random stall bursts, one long hold to back the engine up.
	initial begin
		int hold_left;
		bit pressure_done;
		out_stall     = 1'b0;
		hold_left     = 0;
		pressure_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!pressure_done && predictor != null && predictor.checked >= 40) begin
				hold_left     = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (calm || $urandom_range(0, 5) != 0) begin
				out_stall = 1'b0;
			end else begin
				out_stall = 1'b1;
				hold_left = $urandom_range(1, 15) - 1;
			end
		end
	end

	task automatic push_operation(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] l,
			input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] b, input logic [COLOUR_W-1:0] c);
		int gap;
		@(negedge clk);
		operation = op;
		left      = l;
		top       = t;
		right     = r;
		bottom    = b;
		colour    = c;
		in_valid  = 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predictor.note_operation(op, l, t, r, b, c);
		if (!calm && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic directed_items();
		// Fresh store reads white; far coordinates clamp to the last pixel.
		push_operation(OP_GET, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
		push_operation(OP_GET, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 8'hff);
		push_operation(OP_SET, 12'hfff, 12'hfff, 12'h000, 12'h000, 8'd0);
		push_operation(OP_GET, 12'd255, 12'd127, 12'd0, 12'd0, 8'd0);
		push_operation(OP_SET, 12'd0, 12'd0, 12'hfff, 12'hfff, 8'd0);
		push_operation(OP_GET, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
		push_operation(OP_SET, 12'd0, 12'd0, 12'd0, 12'd0, 8'd1);
		push_operation(OP_GET, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
		// Full-screen rectangles never reach the last column or row.
		push_operation(OP_FILL, 12'd0, 12'd0, 12'hfff, 12'hfff, 8'd0);
		push_operation(OP_GET, 12'd254, 12'd126, 12'd0, 12'd0, 8'd0);
		push_operation(OP_GET, 12'd255, 12'd0, 12'd0, 12'd0, 8'd0);
		push_operation(OP_GET, 12'd0, 12'd127, 12'd0, 12'd0, 8'd0);
		push_operation(OP_INV, 12'd0, 12'd0, 12'hfff, 12'hfff, 8'd0);
		push_operation(OP_GET, 12'd100, 12'd50, 12'd0, 12'd0, 8'd0);
		// Empty rectangles: reversed columns, then zero rows.
		push_operation(OP_FILL, 12'd10, 12'd10, 12'd5, 12'd20, 8'd0);
		push_operation(OP_FILL, 12'd10, 12'd10, 12'd20, 12'd10, 8'd0);
		push_operation(OP_GET, 12'd7, 12'd12, 12'd0, 12'd0, 8'd0);
		// Small invert across byte boundaries, colour ignored.
		push_operation(OP_INV, 12'd3, 12'd2, 12'd13, 12'd5, 8'hff);
		push_operation(OP_GET, 12'd3, 12'd2, 12'd0, 12'd0, 8'd0);
		push_operation(OP_GET, 12'd12, 12'd4, 12'd0, 12'd0, 8'd0);
		push_operation(OP_GET, 12'd13, 12'd4, 12'd0, 12'd0, 8'd0);
		push_operation(OP_FILL, 12'd5, 12'd3, 12'd9, 12'd4, 8'h80);
		push_operation(OP_GET, 12'd6, 12'd3, 12'd0, 12'd0, 8'd0);
		push_operation(OP_SET, 12'd20, 12'd20, 12'hfff, 12'hfff, 8'd0);
		push_operation(OP_GET, 12'd20, 12'd20, 12'hfff, 12'hfff, 8'd0);
	endtask

	// Mostly draw into a region and read it back; now and then hit anywhere.
	task automatic random_items(input int count);
		logic [OP_W-1:0]     op;
		logic [COORD_W-1:0]  l, t, r, b;
		logic [COLOUR_W-1:0] c;
		int k;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count - CALM_TAIL);
			k = $urandom_range(0, 99);
			c = ($urandom_range(0, 3) == 0) ? 8'd0 : COLOUR_W'($urandom_range(1, 255));
			if (k < 55) begin
				op = (k < 25) ? OP_SET : OP_GET;
				if ($urandom_range(0, 5) == 0) begin
					l = COORD_W'($urandom);
					t = COORD_W'($urandom);
				end else begin
					l = COORD_W'(hot_x + $urandom_range(0, 40));
					t = COORD_W'(hot_y + $urandom_range(0, 16));
				end
				r = COORD_W'($urandom);
				b = COORD_W'($urandom);
			end else begin
				op = (k < 78) ? OP_FILL : OP_INV;
				if ($urandom_range(0, 29) == 0) begin
					l = COORD_W'($urandom_range(0, 20));
					t = COORD_W'($urandom_range(0, 10));
					r = '1;
					b = '1;
				end else begin
					l = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom)
						: COORD_W'($urandom_range(0, SCR_W - 1));
					r = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom)
						: COORD_W'(l + $urandom_range(0, 40));
					t = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom)
						: COORD_W'($urandom_range(0, SCR_H - 1));
					b = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom)
						: COORD_W'(t + $urandom_range(0, 14));
				end
				hot_x = (l < SCR_W) ? int'(l) : SCR_W - 41;
				hot_y = (t < SCR_H) ? int'(t) : SCR_H - 17;
				if (hot_x >= 2)
					hot_x -= 2;
				if (hot_y >= 2)
					hot_y -= 2;
			end
			push_operation(op, l, t, r, b, c);
		end
	endtask

	initial begin
		predictor = new();
		cycles    = 0;
		calm      = 1'b0;
		hot_x     = 0;
		hot_y     = 0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_SET;
		left      = '0;
		top       = '0;
		right     = '0;
		bottom    = '0;
		colour    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_items();
		random_items(N_RANDOM);
		@(negedge clk);
		in_valid = 1'b0;

		while (predictor.pending_replies.size() != 0)
			@(posedge clk);
		// Catch any stray result after the last expected one.
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d set, %0d get, %0d fill, %0d invert; %0d results checked",
			predictor.op_count[OP_SET], predictor.op_count[OP_GET],
			predictor.op_count[OP_FILL], predictor.op_count[OP_INV], predictor.checked);
		$display("reads saw %0d lit and %0d dark pixels, %0d mismatches",
			predictor.lit_reads, predictor.dark_reads, predictor.mismatches);
		if (predictor.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
